// ----- hdl/bcpu_pkg.sv -----
// Shared types and operation codes for the byte CPU ALU register step core.
// Depends on nothing; every other file in hdl imports this package.
package bcpu_pkg;

  // Operation codes carried in the action field; codes 22 to 31 are no-ops.
  typedef enum logic [4:0] {
    OP_LDA   = 5'd0,
    OP_STA   = 5'd1,
    OP_LDX   = 5'd2,
    OP_STX   = 5'd3,
    OP_LDY   = 5'd4,
    OP_STY   = 5'd5,
    OP_TAX   = 5'd6,
    OP_TXA   = 5'd7,
    OP_TAY   = 5'd8,
    OP_TYA   = 5'd9,
    OP_ADC   = 5'd10,
    OP_SBC   = 5'd11,
    OP_INC   = 5'd12,
    OP_DEC   = 5'd13,
    OP_INX   = 5'd14,
    OP_DEX   = 5'd15,
    OP_INY   = 5'd16,
    OP_DEY   = 5'd17,
    OP_ASL_A = 5'd18,
    OP_ASL   = 5'd19,
    OP_ROL   = 5'd20,
    OP_ROL_A = 5'd21
  } bcpu_op_t;

  // One instruction beat.
  typedef struct packed {
    logic [4:0]  action;
    logic [7:0]  read_data;
    logic [15:0] address;
  } bcpu_in_t;

  // One result beat.
  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  acc_out;
    logic [7:0]  xreg_out;
    logic [7:0]  yreg_out;
    logic        carry_out;
    logic        zero_out;
    logic        negative_out;
    logic        overflow_out;
  } bcpu_out_t;

  // Architectural registers and flags.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] xreg;
    logic [7:0] yreg;
    logic       carry;
    logic       zero;
    logic       negative;
    logic       overflow;
  } bcpu_state_t;

  localparam logic [7:0] SIGN_BIT  = 8'h80;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

endpackage

// ----- hdl/byte_cpu_alu_register_step_core.sv -----
// Top level of the byte CPU ALU register step core: input register, register file
// and flags, and result register around the execute logic in bcpu_exec.
// Depends on bcpu_pkg and bcpu_exec.
//
// Each item beat is one instruction; the core answers with one result beat holding
// the optional memory write and A, X, Y and the C, Z, N, V flags after it. An item is
// latched into the input register, then executed by the combinational execute logic
// into the result register once that register is free; the core sustains one
// instruction per cycle while the result side does not stall. The register file
// updates in the execute cycle, so each instruction sees the state left by the one
// before it. The input stalls only when both registers hold beats and the result
// side stalls.
module byte_cpu_alu_register_step_core
  import bcpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  bcpu_in_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output bcpu_out_t result
);

  logic        in_reg_valid;
  bcpu_in_t    in_reg;
  bcpu_state_t state;
  bcpu_state_t state_next;
  bcpu_out_t   exec_result;
  logic        advance;
  logic        out_reg_valid;
  bcpu_out_t   out_reg;

  // The held instruction executes whenever the result register is empty or being accepted.
  assign advance    = in_reg_valid && (!out_reg_valid || !result_stall);
  assign item_stall = in_reg_valid && !advance;

  bcpu_exec u_exec (
    .instr      (in_reg),
    .state      (state),
    .state_next (state_next),
    .result     (exec_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_reg <= item;
    end
  end

  // Registers and flags, updated as each instruction executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
    end else if (advance) begin
      out_reg_valid <= 1'b1;
    end else if (!result_stall) begin
      out_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= exec_result;
    end
  end

  assign result_valid = out_reg_valid;
  assign result       = out_reg;

endmodule

// ----- hdl/bcpu_exec.sv -----
// Combinational execute logic: one instruction applied to the register state.
// Depends on bcpu_pkg for the operation codes and the beat and state structs.
module bcpu_exec
  import bcpu_pkg::*;
(
  input  bcpu_in_t    instr,
  input  bcpu_state_t state,
  output bcpu_state_t state_next,
  output bcpu_out_t   result
);

  logic [7:0] operand;
  logic [8:0] sum;
  logic [7:0] shift_src;
  logic       shift_in;
  logic [7:0] shifted;
  logic       write;
  logic [7:0] wdata;
  logic       set_zn;
  logic [7:0] zn_value;

  // Shared adder for ADC and SBC; SBC adds the inverted operand.
  always_comb begin
    operand = (instr.action == OP_SBC) ? ~instr.read_data : instr.read_data;
    sum = {1'b0, state.acc} + {1'b0, operand} + {8'd0, state.carry};
  end

  // Shared shifter for ASL and ROL on the accumulator or the memory byte.
  always_comb begin
    shift_src = (instr.action inside {OP_ASL_A, OP_ROL_A}) ? state.acc : instr.read_data;
    shift_in  = (instr.action inside {OP_ROL, OP_ROL_A}) ? state.carry : 1'b0;
    shifted = {shift_src[6:0], shift_in};
  end

  // Operation select, register update and flag update.
  always_comb begin
    state_next = state;
    write      = 1'b0;
    wdata      = 8'd0;
    set_zn     = 1'b0;
    zn_value   = 8'd0;
    case (instr.action)
      OP_LDA: begin state_next.acc = instr.read_data; set_zn = 1'b1; zn_value = instr.read_data; end
      OP_STA: begin write = 1'b1; wdata = state.acc; end
      OP_LDX: begin state_next.xreg = instr.read_data; set_zn = 1'b1; zn_value = instr.read_data; end
      OP_STX: begin write = 1'b1; wdata = state.xreg; end
      OP_LDY: begin state_next.yreg = instr.read_data; set_zn = 1'b1; zn_value = instr.read_data; end
      OP_STY: begin write = 1'b1; wdata = state.yreg; end
      OP_TAX: begin state_next.xreg = state.acc; set_zn = 1'b1; zn_value = state.acc; end
      OP_TXA: begin state_next.acc = state.xreg; set_zn = 1'b1; zn_value = state.xreg; end
      OP_TAY: begin state_next.yreg = state.acc; set_zn = 1'b1; zn_value = state.acc; end
      OP_TYA: begin state_next.acc = state.yreg; set_zn = 1'b1; zn_value = state.yreg; end
      OP_ADC, OP_SBC: begin
        state_next.acc      = sum[7:0];
        state_next.carry    = sum[8];
        state_next.overflow = |((state.acc ^ sum[7:0]) & (operand ^ sum[7:0]) & SIGN_BIT);
        set_zn   = 1'b1;
        zn_value = sum[7:0];
      end
      OP_INC: begin
        write = 1'b1; wdata = instr.read_data + 8'd1; set_zn = 1'b1;
        zn_value = instr.read_data + 8'd1;
      end
      OP_DEC: begin
        write = 1'b1; wdata = instr.read_data + BYTE_MASK; set_zn = 1'b1;
        zn_value = instr.read_data + BYTE_MASK;
      end
      OP_INX: begin
        state_next.xreg = state.xreg + 8'd1; set_zn = 1'b1; zn_value = state.xreg + 8'd1;
      end
      OP_DEX: begin
        state_next.xreg = state.xreg + BYTE_MASK; set_zn = 1'b1;
        zn_value = state.xreg + BYTE_MASK;
      end
      OP_INY: begin
        state_next.yreg = state.yreg + 8'd1; set_zn = 1'b1; zn_value = state.yreg + 8'd1;
      end
      OP_DEY: begin
        state_next.yreg = state.yreg + BYTE_MASK; set_zn = 1'b1;
        zn_value = state.yreg + BYTE_MASK;
      end
      OP_ASL_A, OP_ROL_A: begin
        state_next.acc   = shifted;
        state_next.carry = shift_src[7];
        set_zn   = 1'b1;
        zn_value = shifted;
      end
      OP_ASL, OP_ROL: begin
        write = 1'b1;
        wdata = shifted;
        state_next.carry = shift_src[7];
        set_zn   = 1'b1;
        zn_value = shifted;
      end
      default: begin
        // Unused codes leave the state alone and write nothing.
        write = 1'b0;
      end
    endcase
    if (set_zn) begin
      state_next.zero     = (zn_value == 8'd0);
      state_next.negative = |(zn_value & SIGN_BIT);
    end
  end

  // Result beat: the write port plus the registers after the instruction.
  always_comb begin
    result.write_valid   = write;
    result.write_address = write ? instr.address : 16'd0;
    result.write_data    = wdata;
    result.acc_out       = state_next.acc;
    result.xreg_out      = state_next.xreg;
    result.yreg_out      = state_next.yreg;
    result.carry_out     = state_next.carry;
    result.zero_out      = state_next.zero;
    result.negative_out  = state_next.negative;
    result.overflow_out  = state_next.overflow;
  end

endmodule
